[rtl/core/pcma_pkg.sv]
// Shared widths, register indexes and fixed-point helpers for the calibrated moving average.
package pcma_pkg;

  localparam int CTS_W       = 16;
  localparam int COEF_W      = 64;
  localparam int ACC_W       = 64;
  localparam int CAL_W       = 48;
  localparam int SAMP_W      = 6;
  localparam int ORDER_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int N_COEF_REGS = 4;
  localparam int DIV_BITS    = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CAL_W-1:0] CAL_MAX = {1'b0, {(CAL_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLY_ORDER = 3'd0,
    CFG_COEF_0     = 3'd1,
    CFG_COEF_1     = 3'd2,
    CFG_COEF_2     = 3'd3,
    CFG_COEF_3     = 3'd4
  } cfg_idx_t;

  // result word handed from the divider to the output register
  typedef struct packed {
    logic [SAMP_W-1:0] samples;
    logic [CAL_W-1:0]  mean;
  } res_t;

  // Q15.48 -> Q23.40, round half up
  function automatic logic signed [ACC_W-1:0] to_q40(input logic [COEF_W-1:0] c);
    logic signed [ACC_W-1:0] sh;
    sh = {{8{c[COEF_W-1]}}, c[COEF_W-1:8]};
    return sh + ACC_W'({1'b0, c[7]});
  endfunction

endpackage

[rtl/core/poly_calibrate_moving_average.sv]
// Top level: config registers, stream handshakes, Horner unit, window store and divider.
//
//   port group   dir   word contents
//   in_*         in    tdata[15:0] raw_counts
//   out_*        out   tdata[47:0] mean_value, tdata[53:48] samples_in_window
//   cfg_*        in    addr = register index, wdata[63:0] value
//
// One word at a time: the Horner unit captures the word, loads, does one multiply and one
// add per further term and rounds; the window store reads the RAM, then writes back with
// the sum update; the divider runs ceil(sum width / 8) restoring steps; the result then
// goes into the output register.
// A new word is taken as soon as the previous result sits in the output register.
// Synchronous reset clears the window store through per-entry valid bits, no sweep.
// A stalled output holds the divider, which holds off the next input word.
module poly_calibrate_moving_average #(
  parameter int WINDOW_LENGTH = 44,
  parameter int MAX_TERMS     = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pcma_pkg::IN_TDATA_W-1:0]     in_tdata,   // [15:0] raw_counts
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pcma_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [47:0] mean_value,
                                                          // [53:48] samples_in_window
  input  logic                                cfg_we,
  input  logic [pcma_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [pcma_pkg::COEF_W-1:0]         cfg_wdata
);

  localparam int TIDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int SUM_W  = pcma_pkg::CAL_W + $clog2(WINDOW_LENGTH);
  localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);

  logic [pcma_pkg::ORDER_W-1:0] order_r;
  logic [pcma_pkg::COEF_W-1:0]  coef_r [MAX_TERMS];
  logic                         busy_r;
  logic                         out_valid_r;
  pcma_pkg::res_t               out_res_r;

  logic [pcma_pkg::ORDER_W:0]   ord_ext;
  logic [TIDX_W-1:0]            last_idx;
  logic                         in_acc;
  logic                         cal_valid;
  logic [pcma_pkg::CAL_W-1:0]   cal;
  logic                         go;
  logic [SUM_W-1:0]             sum;
  logic [CNT_W-1:0]             fill;
  logic                         res_valid;
  pcma_pkg::res_t               res;
  logic                         res_take;

  // order 0 acts as 1, anything above MAX_TERMS as MAX_TERMS
  assign ord_ext = {1'b0, order_r};
  always_comb begin
    if (ord_ext == '0) begin
      last_idx = '0;
    end else if (ord_ext > (pcma_pkg::ORDER_W+1)'(MAX_TERMS)) begin
      last_idx = TIDX_W'(MAX_TERMS - 1);
    end else begin
      last_idx = TIDX_W'(ord_ext - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= (pcma_pkg::ORDER_W)'(1);
    end else if (cfg_we && cfg_addr == pcma_pkg::CFG_POLY_ORDER) begin
      order_r <= cfg_wdata[pcma_pkg::ORDER_W-1:0];
    end
  end

  for (genvar j = 0; j < MAX_TERMS; j++) begin : g_coef
    if (j < pcma_pkg::N_COEF_REGS) begin : g_wr
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          coef_r[j] <= '0;
        end else if (cfg_we &&
                     cfg_addr == pcma_pkg::CFG_IDX_W'(pcma_pkg::CFG_COEF_0 + j)) begin
          coef_r[j] <= cfg_wdata;
        end
      end
    end else begin : g_zero
      always_ff @(posedge clk) begin
        coef_r[j] <= '0;
      end
    end
  end

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && !busy_r;
  assign res_take  = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (res_take) begin
        busy_r <= 1'b0;
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  pcma_horner #(
    .MAX_TERMS (MAX_TERMS),
    .TIDX_W    (TIDX_W)
  ) u_horner (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (in_acc),
    .cts_i      (in_tdata[pcma_pkg::CTS_W-1:0]),
    .last_idx_i (last_idx),
    .coef_i     (coef_r),
    .done_o     (cal_valid),
    .cal_o      (cal)
  );

  pcma_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SUM_W         (SUM_W),
    .CNT_W         (CNT_W)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cal_valid_i (cal_valid),
    .cal_i       (cal),
    .go_o        (go),
    .sum_o       (sum),
    .fill_o      (fill)
  );

  pcma_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .go_i        (go),
    .sum_i       (sum),
    .cnt_i       (fill),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule

[rtl/core/pcma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pcma_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/pcma_horner.sv]
// Horner evaluation of the calibration polynomial with one shared saturating multiply-add.
module pcma_horner #(
  parameter int MAX_TERMS = 4,
  parameter int TIDX_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [pcma_pkg::CTS_W-1:0]    cts_i,
  input  logic [TIDX_W-1:0]             last_idx_i,
  input  logic [pcma_pkg::COEF_W-1:0]   coef_i [MAX_TERMS],
  output logic                          done_o,
  output logic [pcma_pkg::CAL_W-1:0]    cal_o
);

  localparam int AW = pcma_pkg::ACC_W;
  localparam int PW = AW + pcma_pkg::CTS_W + 1;

  typedef enum logic [2:0] {H_IDLE, H_LOAD, H_MUL, H_ADD, H_ROUND} h_state_t;

  h_state_t                      state_r;
  logic [TIDX_W-1:0]             idx_r;
  logic [pcma_pkg::CTS_W-1:0]    cts_r;
  logic signed [AW-1:0]          acc_r;
  logic signed [AW-1:0]          prod_r;
  logic                          done_r;
  logic [pcma_pkg::CAL_W-1:0]    cal_r;

  logic signed [AW-1:0]          coef_q;
  logic signed [PW-1:0]          prod_full;
  logic                          prod_ovf;
  logic signed [AW-1:0]          prod_sat;
  logic signed [AW:0]            sum_full;
  logic signed [AW-1:0]          sum_sat;
  logic signed [pcma_pkg::CAL_W:0] rnd;
  logic [pcma_pkg::CAL_W-1:0]    cal_nxt;

  assign coef_q = pcma_pkg::to_q40(coef_i[idx_r]);

  // acc * counts, clamped to 64 bits
  assign prod_full = acc_r * $signed({1'b0, cts_r});
  assign prod_ovf  = !((&prod_full[PW-1:AW-1]) || !(|prod_full[PW-1:AW-1]));
  assign prod_sat  = prod_ovf ? (prod_full[PW-1] ? {1'b1, {(AW-1){1'b0}}}
                                                 : {1'b0, {(AW-1){1'b1}}})
                              : prod_full[AW-1:0];

  assign sum_full = prod_r + coef_q;
  assign sum_sat  = (sum_full[AW] != sum_full[AW-1])
                  ? (sum_full[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}})
                  : sum_full[AW-1:0];

  // Q23.40 -> Q23.24, half up; only the top end can overflow
  assign rnd     = {acc_r[AW-1], acc_r[AW-1:16]}
                 + (pcma_pkg::CAL_W+1)'({1'b0, acc_r[15]});
  assign cal_nxt = (!rnd[pcma_pkg::CAL_W] && rnd[pcma_pkg::CAL_W-1])
                 ? pcma_pkg::CAL_MAX : rnd[pcma_pkg::CAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        H_IDLE: begin
          if (start_i) begin
            idx_r   <= last_idx_i;
            cts_r   <= cts_i;
            state_r <= H_LOAD;
          end
        end
        H_LOAD: begin
          acc_r   <= coef_q;
          state_r <= (idx_r == '0) ? H_ROUND : H_MUL;
        end
        H_MUL: begin
          prod_r  <= prod_sat;
          idx_r   <= idx_r - 1'b1;
          state_r <= H_ADD;
        end
        H_ADD: begin
          acc_r   <= sum_sat;
          state_r <= (idx_r == '0) ? H_ROUND : H_MUL;
        end
        H_ROUND: begin
          cal_r   <= cal_nxt;
          done_r  <= 1'b1;
          state_r <= H_IDLE;
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign done_o = done_r;
  assign cal_o  = cal_r;

endmodule

[rtl/core/pcma_window.sv]
// Ring store of calibrated values with running sum, write pointer and fill count.
module pcma_window #(
  parameter int WINDOW_LENGTH = 44,
  parameter int SUM_W         = pcma_pkg::CAL_W + $clog2(WINDOW_LENGTH),
  parameter int CNT_W         = $clog2(WINDOW_LENGTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cal_valid_i,
  input  logic [pcma_pkg::CAL_W-1:0]  cal_i,
  output logic                        go_o,
  output logic [SUM_W-1:0]            sum_o,
  output logic [CNT_W-1:0]            fill_o
);

  localparam int WP_W = $clog2(WINDOW_LENGTH);
  localparam int CW   = pcma_pkg::CAL_W;

  typedef enum logic {W_IDLE, W_UPD} w_state_t;

  w_state_t                 state_r;
  logic [WP_W-1:0]          wpos_r;
  logic [CNT_W-1:0]         fill_r;
  logic [SUM_W-1:0]         sum_r;
  logic [WINDOW_LENGTH-1:0] vld_r;
  logic [CW-1:0]            cal_r;
  logic                     go_r;

  logic [CW-1:0]            rdata;
  logic [CW-1:0]            old_val;
  logic [SUM_W-1:0]         sum_nxt;
  logic                     ram_we;

  assign ram_we = (state_r == W_UPD);

  pcma_ram #(
    .WIDTH (CW),
    .DEPTH (WINDOW_LENGTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos_r),
    .wdata (cal_r),
    .re    (cal_valid_i),
    .raddr (wpos_r),
    .rdata (rdata)
  );

  // entries never written since reset read as zero
  assign old_val = vld_r[wpos_r] ? rdata : '0;
  assign sum_nxt = sum_r - {{(SUM_W-CW){old_val[CW-1]}}, old_val}
                         + {{(SUM_W-CW){cal_r[CW-1]}}, cal_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      wpos_r  <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      vld_r   <= '0;
      go_r    <= 1'b0;
    end else begin
      go_r <= 1'b0;
      unique case (state_r)
        W_IDLE: begin
          if (cal_valid_i) begin
            cal_r   <= cal_i;
            state_r <= W_UPD;
          end
        end
        W_UPD: begin
          sum_r         <= sum_nxt;
          vld_r[wpos_r] <= 1'b1;
          wpos_r        <= (wpos_r == WP_W'(WINDOW_LENGTH - 1)) ? '0 : wpos_r + 1'b1;
          if (fill_r < CNT_W'(WINDOW_LENGTH)) begin
            fill_r <= fill_r + 1'b1;
          end
          go_r    <= 1'b1;
          state_r <= W_IDLE;
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  assign go_o   = go_r;
  assign sum_o  = sum_r;
  assign fill_o = fill_r;

endmodule

[rtl/core/pcma_div.sv]
// Sign-magnitude rounding divider, DIV_BITS quotient bits per cycle.
module pcma_div #(
  parameter int SUM_W = 54,
  parameter int CNT_W = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go_i,
  input  logic [SUM_W-1:0]     sum_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output logic                 res_valid_o,
  output pcma_pkg::res_t       res_o,
  input  logic                 res_take_i
);

  localparam int DB        = pcma_pkg::DIV_BITS;
  localparam int DIV_STEPS = (SUM_W + DB - 1) / DB;
  localparam int NUM_W     = DIV_STEPS * DB;
  localparam int ST_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int CW        = pcma_pkg::CAL_W;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_HOLD} d_state_t;

  d_state_t          state_r;
  logic [ST_W-1:0]   step_r;
  logic [NUM_W-1:0]  num_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  den_r;
  logic              neg_r;

  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  num_init;
  logic [NUM_W-1:0]  num_nxt;
  logic [CNT_W-1:0]  rem_nxt;
  logic [CNT_W+5:0]  den_ext;

  assign neg      = sum_i[SUM_W-1];
  assign mag      = neg ? (~sum_i + 1'b1) : sum_i;
  assign num_init = mag + SUM_W'(cnt_i >> 1);

  // restoring steps, numerator shifted out MSB first, quotient shifted in
  always_comb begin
    logic [CNT_W:0]   t;
    logic [NUM_W-1:0] n;
    logic [CNT_W-1:0] r;
    n = num_r;
    r = rem_r;
    for (int i = 0; i < DB; i++) begin
      t = {r, n[NUM_W-1]};
      n = {n[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t    = t - {1'b0, den_r};
        n[0] = 1'b1;
      end
      r = t[CNT_W-1:0];
    end
    num_nxt = n;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      unique case (state_r)
        D_IDLE: begin
          if (go_i) begin
            num_r   <= NUM_W'(num_init);
            rem_r   <= '0;
            den_r   <= cnt_i;
            neg_r   <= neg;
            step_r  <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          num_r  <= num_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == ST_W'(DIV_STEPS - 1)) begin
            state_r <= D_HOLD;
          end
        end
        D_HOLD: begin
          if (res_take_i) begin
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign den_ext       = {6'b0, den_r};
  assign res_valid_o   = (state_r == D_HOLD);
  assign res_o.mean    = neg_r ? (~num_r[CW-1:0] + 1'b1) : num_r[CW-1:0];
  assign res_o.samples = den_ext[pcma_pkg::SAMP_W-1:0];

endmodule

[test/tb_poly_calibrate_moving_average.sv]
// Testbench for the calibrated housekeeping channel with boxcar moving average.
module tb_poly_calibrate_moving_average;
  import pcma_pkg::*;

  localparam int WIN_LEN      = 44;
  localparam int MAX_TERMS    = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 400000;

  localparam longint CAL_TOP = 64'sh0000_7FFF_FFFF_FFFF;

  typedef struct {
    logic [CAL_W-1:0]  mean;
    logic [SAMP_W-1:0] samples;
  } calib_mean_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [15:0] raw_counts
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [47:0] mean_value, [53:48] samples_in_window
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [COEF_W-1:0]      cfg_wdata = '0;

  // calibration settings and window as the block should hold them
  logic [ORDER_W-1:0] order_reg;
  longint             coef_q48 [N_COEF_REGS];
  longint             window_vals [WIN_LEN];
  longint             window_total;
  int                 window_wr;
  int                 window_fill;

  calib_mean_t expected_means [$];
  int          fault_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  poly_calibrate_moving_average i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_fault(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    fault_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_to_64(input logic signed [95:0] v);
    if (v > $signed({32'd0, 64'h7FFF_FFFF_FFFF_FFFF}))
      return 64'h7FFF_FFFF_FFFF_FFFF;
    if (v < $signed({32'hFFFF_FFFF, 64'h8000_0000_0000_0000}))
      return 64'h8000_0000_0000_0000;
    return v[63:0];
  endfunction

  // Q15.48 to Q23.40, floor plus the bit just below the cut
  function automatic longint coef_to_q40(input longint c);
    longint r;
    r = c >>> 8;
    r = r + longint'(c[7]);
    return r;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < WIN_LEN; i++) window_vals[i] = 0;
    for (int i = 0; i < N_COEF_REGS; i++) coef_q48[i] = 0;
    window_total = 0;
    window_wr = 0;
    window_fill = 0;
    order_reg = 1;
  endfunction

  function automatic calib_mean_t predict_mean(input logic [CTS_W-1:0] cts);
    int                   terms;
    longint               acc;
    longint               cal;
    logic signed [95:0]   acc_w;
    logic signed [95:0]   cts_w;
    logic signed [95:0]   add_w;
    logic [63:0]          mag;
    logic [63:0]          quot;
    logic [63:0]          mean_w;
    calib_mean_t          res;
    terms = (order_reg == 0) ? 1 : ((order_reg > MAX_TERMS) ? MAX_TERMS : int'(order_reg));
    acc = coef_to_q40(coef_q48[terms-1]);
    cts_w = {80'd0, cts};
    for (int k = terms - 1; k > 0; k--) begin
      acc_w = acc;
      acc = clamp_to_64(acc_w * cts_w);
      acc_w = acc;
      add_w = coef_to_q40(coef_q48[k-1]);
      acc = clamp_to_64(acc_w + add_w);
    end
    cal = acc >>> 16;
    cal = cal + longint'(acc[15]);
    if (cal > CAL_TOP) cal = CAL_TOP;

    window_total = window_total - window_vals[window_wr] + cal;
    window_vals[window_wr] = cal;
    window_wr = (window_wr + 1) % WIN_LEN;
    if (window_fill < WIN_LEN) window_fill++;

    mag = (window_total < 0) ? -window_total : window_total;
    quot = (mag + window_fill / 2) / window_fill;
    mean_w = (window_total < 0) ? -quot : quot;
    res.mean = mean_w[CAL_W-1:0];
    res.samples = window_fill[SAMP_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    calib_mean_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_means.size() == 0) begin
        report_fault($sformatf("unexpected result word %h", out_tdata));
      end else begin
        want = expected_means.pop_front();
        if (out_tdata[CAL_W-1:0] !== want.mean)
          report_fault($sformatf("mean_value got %h want %h",
                                 out_tdata[CAL_W-1:0], want.mean));
        if (out_tdata[CAL_W +: SAMP_W] !== want.samples)
          report_fault($sformatf("samples_in_window got %0d want %0d",
                                 out_tdata[CAL_W +: SAMP_W], want.samples));
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // tvalid stays high after a word until an idle gap before the next word or drain() lowers it
  task automatic send_count(input logic [CTS_W-1:0] cts);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= cts;
    do @(posedge clk); while (!in_tready);
    expected_means.push_back(predict_mean(cts));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val,
                           input bit last);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_POLY_ORDER)
      order_reg = val[ORDER_W-1:0];
    else if (idx >= CFG_COEF_0 && idx <= CFG_COEF_3)
      coef_q48[idx - CFG_COEF_0] = val;
    if (last) cfg_we <= 1'b0;
  endtask

  task automatic load_setting(input logic [COEF_W-1:0] order, input logic [COEF_W-1:0] c0,
                              input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
                              input logic [COEF_W-1:0] c3);
    write_reg(CFG_COEF_0, c0, 1'b0);
    write_reg(CFG_COEF_1, c1, 1'b0);
    write_reg(CFG_COEF_2, c2, 1'b0);
    write_reg(CFG_COEF_3, c3, 1'b0);
    write_reg(CFG_POLY_ORDER, order, 1'b1);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    logic [COEF_W-1:0] mag;
    mag = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return mag;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'h8000_0000_0000_0000;
      3: return '0;
      default: begin
        // magnitudes spread so that some orders stay clear of saturation
        mag = mag >> $urandom_range(8, 62);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [CTS_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CTS_W'($urandom_range(0, 255));
      default: return CTS_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    // constant term of zero: means stay zero while the count climbs
    send_count('0);
    send_count('1);
    send_count(16'd12345);
    drain();
  endtask

  task automatic test_order_limits();
    // order zero acts as constant only
    load_setting(0, 64'h0001_2345_6789_ABCD, 64'h0000_0100_0000_0000,
                 64'h0000_0000_1000_0000, 64'h0000_0000_0001_0000);
    send_count(16'd1000);
    send_count('1);
    drain();
    // order above the term count uses all four terms
    write_reg(CFG_POLY_ORDER, '1, 1'b1);
    send_count(16'd3);
    send_count(16'd40000);
    drain();
    // writes past the last coefficient must change nothing
    for (int idx = int'(CFG_COEF_3) + 1; idx < 2 ** CFG_IDX_W; idx++)
      write_reg(CFG_IDX_W'(idx), {$urandom, $urandom}, idx == 2 ** CFG_IDX_W - 1);
    send_count(16'd3);
    drain();
  endtask

  task automatic test_saturation_and_rounding();
    load_setting(4, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send_count('1);
    send_count('0);
    drain();
    load_setting(4, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_count('1);
    send_count('0);
    drain();
    // mixed signs: product saturates one way, the add pulls it back
    load_setting(2, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    send_count('1);
    send_count(16'd1);
    drain();
    // half-LSB cases in the coefficient shift and the final shift
    load_setting(1, 64'h0000_0000_0080_8080, '0, '0, '0);
    send_count(16'd7);
    drain();
    write_reg(CFG_COEF_0, -64'sh0000_0000_0080_8080, 1'b1);
    send_count(16'd7);
    drain();
    load_setting(2, -64'sd1, 64'h0000_0000_0000_8100, '0, '0);
    for (int i = 0; i < 4; i++) send_count(CTS_W'(i + 1));
    drain();
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int n_items);
    int left;
    int chunk;
    logic [COEF_W-1:0] order;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    left = n_items;
    while (left > 0) begin
      drain();
      if ($urandom_range(0, 9) == 0) order = $urandom_range(0, 7);
      else order = $urandom_range(1, MAX_TERMS);
      load_setting(order, pick_coef(), pick_coef(), pick_coef(), pick_coef());
      chunk = $urandom_range(20, 80);
      if (chunk > left) chunk = left;
      for (int i = 0; i < chunk; i++) send_count(pick_count());
      left -= chunk;
    end
  endtask

  initial begin
    clear_window();
    send_idle_pct = 17;
    recv_idle_pct = 66;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_order_limits();
    test_saturation_and_rounding();
    test_random_traffic(17, 66, 290);
    test_random_traffic(66, 17, 280);
    test_random_traffic(0, 0, 280);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_means.size() != 0)
      report_fault($sformatf("%0d results never arrived", expected_means.size()));
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pcma_pkg.sv
rtl/core/pcma_ram.sv
rtl/core/pcma_horner.sv
rtl/core/pcma_window.sv
rtl/core/pcma_div.sv
rtl/core/poly_calibrate_moving_average.sv
test/tb_poly_calibrate_moving_average.sv
